@@ design/d8_flow_direction_assert.svh @@
// Assertion macros for the D8 flow-direction block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef D8_FLOW_DIRECTION_ASSERT_SVH
`define D8_FLOW_DIRECTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D8_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define D8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/d8_pkg.sv @@
// Shared types, constants and the direction-select function of the D8 block.
// No dependencies; the front, queue, back and top-level files import this package.
package d8_pkg;

    localparam int HEIGHT_BITS = 16;
    localparam int MAX_WIDTH   = 256;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WCFG_W      = 9;
    localparam int ROW_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int DIR_COUNT   = 8;
    localparam int DIR_W       = 4;
    localparam int DIR_IDX_W   = $clog2(DIR_COUNT);

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Register reset values and legal limits.
    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 9'd256;
    localparam logic [ROW_W-1:0]  HEIGHT_RESET = 16'd256;
    localparam logic [WCFG_W-1:0] WIDTH_MIN    = 9'd2;
    localparam logic [WCFG_W-1:0] WIDTH_MAX    = WCFG_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0]  HEIGHT_MIN   = 16'd2;

    localparam logic signed [DIR_W-1:0] DIR_NONE = -4'sd1;

    // Window row and column of the neighbour in each direction (centre is 1,1).
    localparam logic [1:0] NB_ROW [DIR_COUNT] =
        '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};
    localparam logic [1:0] NB_COL [DIR_COUNT] =
        '{2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2};

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_DRAIN  = 1'b1
    } t_op;

    typedef enum logic [0:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [HEIGHT_BITS-1:0] t_height;

    // 3x3 window, indexed [row][column].
    typedef logic [2:0][2:0][HEIGHT_BITS-1:0] t_win;

    // One column of the last two rows: [0] older row, [1] newer row.
    typedef logic [1:0][HEIGHT_BITS-1:0] t_col2;

    typedef struct packed {
        t_op                    operation;
        logic [HEIGHT_BITS-1:0] height_sample;
    } t_item;

    typedef struct packed {
        logic signed [DIR_W-1:0] direction;
        logic [COL_W-1:0]        cell_x;
        logic [ROW_W-1:0]        cell_z;
        logic                    last_of_run;
        logic                    last_of_frame;
    } t_res;

    // Classified work item passed from the front to the back.
    typedef struct packed {
        logic             is_drain;
        logic             emit_main;
        logic             emit_tail;
        logic             row_up_ok;
        logic             left_ok;
        logic             right_ok;
        logic             prime_drain;
        logic             last_frame;
        logic [COL_W-1:0] cell_x;
        logic [ROW_W-1:0] cell_z;
        t_height          sample;
        t_height          older;
        t_height          newer;
    } t_cmd;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_qstat;

    // Steepest-descent direction of the window centre. A neighbour competes
    // when its row and column are valid and it lies strictly below the
    // centre; the lowest neighbour wins and a tie goes to the lower index.
    function automatic logic signed [DIR_W-1:0] d8_direction(
        input t_win       w,
        input logic [2:0] vr,
        input logic [2:0] vc
    );
        logic [DIR_COUNT-1:0] ok;
        t_height              val [DIR_COUNT];
        logic [DIR_IDX_W-1:0] idx [DIR_COUNT];
        for (int d = 0; d < DIR_COUNT; d++) begin
            val[d] = w[NB_ROW[d]][NB_COL[d]];
            idx[d] = DIR_IDX_W'(d);
            ok[d]  = vr[NB_ROW[d]] && vc[NB_COL[d]] && (val[d] < w[1][1]);
        end
        // Pairwise reduction tree; the left operand always has the lower index.
        for (int s = 1; s < DIR_COUNT; s = s * 2) begin
            for (int i = 0; i + s < DIR_COUNT; i = i + 2 * s) begin
                if (ok[i + s] && (!ok[i] || (val[i + s] < val[i]))) begin
                    ok[i]  = 1'b1;
                    val[i] = val[i + s];
                    idx[i] = idx[i + s];
                end
            end
        end
        return ok[0] ? $signed({1'b0, idx[0]}) : DIR_NONE;
    endfunction

endpackage

@@ design/d8_ram.sv @@
// Generic single-write, single-read memory with a registered, read-first output.
// No dependencies; used for the two line stores.
module d8_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/d8_front.sv @@
// Front end of the D8 block: item intake, raster counters, line stores and classification.
// Depends on d8_pkg and d8_ram; feeds classified work to d8_queue.
module d8_front
    import d8_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_stall,
    input  logic                  i_cfg_valid,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    input  t_qstat                i_qstat,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [WCFG_W-1:0] r_grid_width;
    logic [ROW_W-1:0]  r_grid_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_drain, n_drain;
    logic              r_s1_valid;
    logic              r_s1_par;
    t_cmd              r_s1_cmd, n_s1_cmd;

    logic [WCFG_W-1:0] w_eff, w_eff_m1;
    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_eff, h_last;
    logic              accept, is_drain, frame_done;
    logic              take_sample, take_drain;
    logic              col_end, drain_end;
    logic              cfg_write;
    logic [COL_W-1:0]  raddr;
    t_height           rdata0, rdata1;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Effective grid size after clamping out-of-range register values.
    always_comb begin
        if (r_grid_width < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (r_grid_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_grid_width;
        end
        h_eff = (r_grid_height < HEIGHT_MIN) ? HEIGHT_MIN : r_grid_height;
    end

    assign w_eff_m1 = w_eff - WCFG_W'(1);
    assign w_last   = w_eff_m1[COL_W-1:0];
    assign h_last   = h_eff - ROW_W'(1);

    // Stall while the queue could not absorb the item now in the read stage.
    assign o_stall = (i_qstat.count + QCNT_W'(r_s1_valid)) >= QCNT_W'(QDEPTH);

    assign accept      = i_valid && !o_stall;
    assign is_drain    = (i_item.operation == OP_DRAIN);
    assign frame_done  = (r_row >= h_eff);
    assign take_sample = accept && !is_drain && !frame_done;
    assign take_drain  = accept && is_drain && frame_done;
    assign col_end     = (r_col >= w_last);
    assign drain_end   = (r_drain >= w_last);

    // Row r is written to bank r[0]; the other bank holds the row above.
    assign raddr = is_drain ? (r_drain + COL_W'(1)) : r_col;

    d8_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (take_sample && !r_row[0]),
        .i_waddr (r_col),
        .i_wdata (i_item.height_sample),
        .i_raddr (raddr),
        .o_rdata (rdata0)
    );

    d8_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (take_sample && r_row[0]),
        .i_waddr (r_col),
        .i_wdata (i_item.height_sample),
        .i_raddr (raddr),
        .o_rdata (rdata1)
    );

    // Raster and drain counters.
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        if (cfg_write) begin
            n_col   = '0;
            n_row   = '0;
            n_drain = '0;
        end else if (take_sample) begin
            if (col_end) begin
                n_col   = '0;
                n_row   = r_row + ROW_W'(1);
                n_drain = '0;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end else if (take_drain) begin
            if (drain_end) begin
                n_col   = '0;
                n_row   = '0;
                n_drain = '0;
            end else begin
                n_drain = r_drain + COL_W'(1);
            end
        end
    end

    // Classify the accepted item: which results it causes and which
    // neighbours are inside the grid.
    always_comb begin
        n_s1_cmd        = '0;
        n_s1_cmd.sample = i_item.height_sample;
        if (is_drain) begin
            n_s1_cmd.is_drain   = 1'b1;
            n_s1_cmd.emit_main  = 1'b1;
            n_s1_cmd.row_up_ok  = 1'b1;
            n_s1_cmd.left_ok    = (r_drain != '0);
            n_s1_cmd.right_ok   = !drain_end;
            n_s1_cmd.last_frame = (r_drain == w_last);
            n_s1_cmd.cell_x     = r_drain;
            n_s1_cmd.cell_z     = h_last;
        end else begin
            n_s1_cmd.emit_main   = (r_row != '0) && (r_col != '0);
            n_s1_cmd.emit_tail   = (r_row != '0) && col_end;
            n_s1_cmd.row_up_ok   = (r_row >= ROW_W'(2));
            n_s1_cmd.left_ok     = (r_col >= COL_W'(2));
            n_s1_cmd.right_ok    = 1'b1;
            n_s1_cmd.prime_drain = (r_row == h_last) && (r_col == '0);
            n_s1_cmd.cell_x      = r_col - COL_W'(1);
            n_s1_cmd.cell_z      = r_row - ROW_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= WIDTH_RESET;
            r_grid_height <= HEIGHT_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_drain       <= '0;
            r_s1_valid    <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_drain    <= n_drain;
            r_s1_valid <= take_sample || take_drain;
            if (cfg_write) begin
                unique case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[WCFG_W-1:0];
                    CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[ROW_W-1:0];
                endcase
            end
        end
    end

    // Read-stage payload, aligned with the registered store data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd <= n_s1_cmd;
            r_s1_par <= r_row[0];
        end
    end

    // Attach the store data: the older row sits in the bank of the current row parity.
    always_comb begin
        o_cmd       = r_s1_cmd;
        o_cmd.older = r_s1_par ? rdata1 : rdata0;
        o_cmd.newer = r_s1_par ? rdata0 : rdata1;
    end

    assign o_push = r_s1_valid;

endmodule

@@ design/d8_queue.sv @@
// Short queue of classified work between the front and the back of the D8 block.
// Depends on d8_pkg.
module d8_queue
    import d8_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_head,
    output t_qstat o_qstat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_head        = r_mem[r_rptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.count = r_count;

endmodule

@@ design/d8_back.sv @@
// Back end of the D8 block: 3x3 window, drain window, direction select and output register.
// Depends on d8_pkg; takes its work from d8_queue.
module d8_back
    import d8_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_head,
    input  t_qstat i_qstat,
    output logic   o_pop,
    output logic   o_valid,
    output t_res   o_res,
    input  logic   i_stall
);

    t_win              r_win, win_next, main_win, tail_win, drain_win;
    t_col2 [2:0]       r_dcol, drain_next;
    logic              r_tail_pend;
    logic [COL_W-1:0]  r_tail_x;
    logic [ROW_W-1:0]  r_tail_z;
    logic              r_tail_rowup;
    logic              r_out_valid;
    t_res              r_out;

    logic [2:0]        main_vr, main_vc;
    logic              can_load, head_valid, load_tail, load_main;
    t_res              main_res, tail_res;

    assign can_load   = !r_out_valid || !i_stall;
    assign head_valid = !i_qstat.empty;
    assign load_tail  = r_tail_pend && can_load;
    assign o_pop      = head_valid && !r_tail_pend && (can_load || !i_head.emit_main);
    assign load_main  = o_pop && i_head.emit_main;

    // Sample window after shifting in the new column.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i][0] = r_win[i][1];
            win_next[i][1] = r_win[i][2];
            tail_win[i][0] = r_win[i][1];
            tail_win[i][1] = r_win[i][2];
            tail_win[i][2] = '0;
        end
        win_next[0][2] = i_head.older;
        win_next[1][2] = i_head.newer;
        win_next[2][2] = i_head.sample;
    end

    // Drain window: the last two rows, one column further on per drain item.
    always_comb begin
        drain_next[0] = r_dcol[1];
        drain_next[1] = r_dcol[2];
        drain_next[2] = {i_head.newer, i_head.older};
        for (int k = 0; k < 3; k++) begin
            drain_win[0][k] = drain_next[k][0];
            drain_win[1][k] = drain_next[k][1];
            drain_win[2][k] = '0;
        end
    end

    // Window and validity masks of the head item's main result.
    always_comb begin
        if (i_head.is_drain) begin
            main_win = drain_win;
            main_vr  = 3'b011;
            main_vc  = {i_head.right_ok, 1'b1, i_head.left_ok};
        end else begin
            main_win = win_next;
            main_vr  = {1'b1, 1'b1, i_head.row_up_ok};
            main_vc  = {1'b1, 1'b1, i_head.left_ok};
        end
    end

    always_comb begin
        main_res.direction     = d8_direction(main_win, main_vr, main_vc);
        main_res.cell_x        = i_head.cell_x;
        main_res.cell_z        = i_head.cell_z;
        main_res.last_of_run   = !i_head.emit_tail;
        main_res.last_of_frame = i_head.last_frame;

        // The row's last cell has no column to its right.
        tail_res.direction     = d8_direction(tail_win, {1'b1, 1'b1, r_tail_rowup}, 3'b011);
        tail_res.cell_x        = r_tail_x;
        tail_res.cell_z        = r_tail_z;
        tail_res.last_of_run   = 1'b1;
        tail_res.last_of_frame = 1'b0;
    end

    // Control state: output valid and the pending second result of a row end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tail_pend <= 1'b0;
        end else begin
            if (can_load) begin
                r_out_valid <= load_tail || load_main;
            end
            if (load_tail) begin
                r_tail_pend <= 1'b0;
            end else if (o_pop) begin
                r_tail_pend <= i_head.emit_tail;
            end
        end
    end

    // Windows and output payload.
    always_ff @(posedge i_clk) begin
        if (load_tail) begin
            r_out <= tail_res;
        end else if (load_main) begin
            r_out <= main_res;
        end
        if (o_pop) begin
            if (i_head.is_drain) begin
                r_dcol <= drain_next;
            end else begin
                r_win        <= win_next;
                r_tail_x     <= i_head.cell_x + COL_W'(1);
                r_tail_z     <= i_head.cell_z;
                r_tail_rowup <= i_head.row_up_ok;
                // First column of the last row seeds the drain window.
                if (i_head.prime_drain) begin
                    r_dcol[2] <= {i_head.sample, i_head.newer};
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

@@ design/d8_flow_direction.sv @@
// D8 flow direction over a raster height grid. A main result passes through the read-stage
// register and the queue into the output register after the transfer of the item that
// completes its window; the second result of a row end follows it into the output register.
// Items are taken one per cycle while o_stall is low. From the second row on, a row end
// yields two results and keeps the back end off the queue while the second is loaded, so
// the four-entry queue can fill and stall the intake. Each drain item yields one result.
// Reset is synchronous and active low: counters, queue, output and the grid size
// (256 by 256) are reset; the line stores are not cleared and need no clearing pass.
`include "d8_flow_direction_assert.svh"

module d8_flow_direction
    import d8_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_res                  o_res,
    input  logic                  i_stall,
    input  logic                  i_cfg_valid,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    logic   q_push, q_pop;
    t_cmd   q_in, q_head;
    t_qstat q_stat;

    // Intake, counters and line stores.
    d8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_qstat     (q_stat),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    // Decoupling queue.
    d8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_qstat (q_stat)
    );

    // Window, direction select and result transfer.
    d8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_qstat (q_stat),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .o_res   (o_res),
        .i_stall (i_stall)
    );

    // The front only pushes when the queue has room, the back only pops a
    // filled queue, and a row end keeps the back off the queue while its second result is pending.
    `D8_ASSERT_SAME(a_push_room, q_push, !q_stat.full, "push into a full queue")
    `D8_ASSERT_SAME(a_pop_filled, q_pop, !q_stat.empty, "pop from an empty queue")
    `D8_ASSERT_NEXT(a_tail_hold, q_pop && q_head.emit_tail, !q_pop, "pop during row end")
    `D8_ASSERT_SAME(a_dir_legal, o_valid,
        !o_res.direction[3] || (o_res.direction == DIR_NONE), "illegal direction code")

endmodule
